// ===== sv/hhlp_pkg.sv =====
// Shared constants, field widths and payload types of the HTTP header Host and Content-Length parser.
package hhlp_pkg;

   localparam int MAX_HOST    = 256;
   localparam int MAX_PORT    = 16;
   localparam int LENGTH_BITS = 64;

   localparam int HIDX_W  = $clog2(MAX_HOST);
   localparam int HCNT_W  = $clog2(MAX_HOST + 1);
   localparam int PIDX_W  = $clog2(MAX_PORT);
   localparam int PCNT_W  = $clog2(MAX_PORT + 1);
   localparam int ACC_X_W = LENGTH_BITS + 4;

   localparam int MODE_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 8;
   localparam int HLEN_W  = 9;
   localparam int PLEN_W  = 5;
   localparam int CLEN_W  = 64;

   localparam int HCMP_W = HCNT_W + INDEX_W;
   localparam int PCMP_W = PCNT_W + INDEX_W;

   localparam logic [MODE_W-1:0] MODE_MSG  = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_HOST = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_PORT = MODE_W'(2);

   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_READ    = 1'b1;

   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_EIGHT = 8'h38;

   localparam logic [BYTE_W-1:0] HOST_WORD [4] = '{8'h48, 8'h6F, 8'h73, 8'h74};
   localparam logic [BYTE_W-1:0] CLEN_WORD [16] = '{
      8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
      8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h00, 8'h00};

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [BYTE_W-1:0]  data_byte;
      logic               first_byte;
      logic               last_byte;
      logic [INDEX_W-1:0] read_index;
   } req_item_type;

   typedef struct packed {
      logic               kind;
      logic [BYTE_W-1:0]  read_byte;
      logic [HLEN_W-1:0]  host_length;
      logic [PLEN_W-1:0]  port_length;
      logic               host_missing;
      logic               port_defaulted;
      logic               host_truncated;
      logic               port_truncated;
      logic               length_found;
      logic [CLEN_W-1:0]  content_length;
   } rsp_item_type;

   typedef struct packed {
      logic         has_result;
      logic         host_read;
      logic         host_hit;
      rsp_item_type rsp;
   } core_result_type;

endpackage

// ===== sv/hhlp_req_if.sv =====
// Request channel carrying one message byte or one store read request.
interface hhlp_req_if import hhlp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [BYTE_W-1:0]  data_byte;
   logic               first_byte;
   logic               last_byte;
   logic [INDEX_W-1:0] read_index;

   modport source (output valid, mode, data_byte, first_byte, last_byte, read_index,
                   input ready);
   modport sink (input valid, mode, data_byte, first_byte, last_byte, read_index,
                 output ready);
endinterface

// ===== sv/hhlp_rsp_if.sv =====
// Response channel carrying a message summary or a store read result.
interface hhlp_rsp_if import hhlp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [BYTE_W-1:0] read_byte;
   logic [HLEN_W-1:0] host_length;
   logic [PLEN_W-1:0] port_length;
   logic              host_missing;
   logic              port_defaulted;
   logic              host_truncated;
   logic              port_truncated;
   logic              length_found;
   logic [CLEN_W-1:0] content_length;

   modport source (output valid, kind, read_byte, host_length, port_length, host_missing,
                   port_defaulted, host_truncated, port_truncated, length_found,
                   content_length, input ready);
   modport sink (input valid, kind, read_byte, host_length, port_length, host_missing,
                 port_defaulted, host_truncated, port_truncated, length_found,
                 content_length, output ready);
endinterface

// ===== sv/hhlp_ram.sv =====
// Generic single-port-write RAM with a registered read port.
module hhlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/hhlp_core.sv =====
// Parse state, per-byte update logic, host and port stores of the header parser.
module hhlp_core import hhlp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  req_item_type    item,
   output core_result_type result,
   output logic [BYTE_W-1:0] host_q
);
   localparam logic [3:0] NAME_HOST_LEN = 4'd4;
   localparam logic [3:0] NAME_CLEN_LEN = 4'd14;
   localparam logic [3:0] NAME_POS_MAX  = 4'd15;

   typedef enum logic [3:0] {
      PH_START = 4'b0001,
      PH_NAME  = 4'b0010,
      PH_VALUE = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic                   cr_pending;
      logic [3:0]             name_pos;
      logic                   host_match;
      logic                   len_match;
      logic                   value_begun;
      logic                   value_nonempty;
      logic                   host_colon;
      logic [LENGTH_BITS-1:0] len_acc;
      logic                   len_ok;
      logic                   len_done;
      logic [LENGTH_BITS-1:0] len_value;
      logic [HCNT_W-1:0]      host_count;
      logic [PCNT_W-1:0]      port_count;
      logic                   host_ovf;
      logic                   port_ovf;
   } parse_state_type;

   typedef struct packed {
      parse_state_type   st;
      logic              host_we;
      logic [HIDX_W-1:0] host_addr;
      logic              port_we;
      logic [PIDX_W-1:0] port_addr;
   } content_out_type;

   function automatic parse_state_type cleared_state();
      parse_state_type s;
      s       = '0;
      s.phase = PH_START;
      return s;
   endfunction

   function automatic parse_state_type start_name(parse_state_type s_i);
      parse_state_type s;
      s                = s_i;
      s.phase          = PH_NAME;
      s.name_pos       = '0;
      s.host_match     = 1'b1;
      s.len_match      = 1'b1;
      s.value_begun    = 1'b0;
      s.value_nonempty = 1'b0;
      return s;
   endfunction

   function automatic parse_state_type end_line(parse_state_type s_i);
      parse_state_type s;
      s = s_i;
      unique case (s_i.phase)
         PH_START: begin
            s = start_name(s_i);
         end
         PH_NAME: begin
            if (s_i.name_pos == '0) begin
               s.phase = PH_DONE;
            end else begin
               s = start_name(s_i);
            end
         end
         PH_VALUE: begin
            if (s_i.len_match && s_i.value_nonempty && s_i.len_ok && !s_i.len_done) begin
               s.len_done  = 1'b1;
               s.len_value = s_i.len_acc;
            end
            s = start_name(s);
         end
         default: begin
            s = s_i;
         end
      endcase
      return s;
   endfunction

   function automatic content_out_type apply_content(parse_state_type s_i,
                                                     logic [BYTE_W-1:0] b);
      content_out_type      o;
      logic                 digit;
      logic                 ok;
      logic [3:0]           dval;
      logic [ACC_X_W-1:0]   prod;
      o           = '0;
      o.st        = s_i;
      digit       = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      dval        = 4'(b - CHAR_ZERO);
      prod        = (ACC_X_W'(s_i.len_acc) << 3) + (ACC_X_W'(s_i.len_acc) << 1)
                    + ACC_X_W'(dval);
      ok          = s_i.len_ok;
      if (s_i.phase == PH_NAME) begin
         if (b == CHAR_COLON) begin
            o.st.host_match = s_i.host_match && (s_i.name_pos == NAME_HOST_LEN);
            o.st.len_match  = s_i.len_match && (s_i.name_pos == NAME_CLEN_LEN)
                              && !s_i.len_done;
            if (o.st.host_match) begin
               o.st.host_count = '0;
               o.st.host_ovf   = 1'b0;
               o.st.host_colon = 1'b0;
            end
            if (o.st.len_match) begin
               o.st.len_acc = '0;
               o.st.len_ok  = 1'b0;
            end
            o.st.value_begun    = 1'b0;
            o.st.value_nonempty = 1'b0;
            o.st.phase          = PH_VALUE;
         end else begin
            if (!((s_i.name_pos < NAME_HOST_LEN) && (b == HOST_WORD[s_i.name_pos[1:0]]))) begin
               o.st.host_match = 1'b0;
            end
            if (!((s_i.name_pos < NAME_CLEN_LEN) && (b == CLEN_WORD[s_i.name_pos]))) begin
               o.st.len_match = 1'b0;
            end
            if (s_i.name_pos < NAME_POS_MAX) begin
               o.st.name_pos = s_i.name_pos + 4'd1;
            end
         end
      end else if (s_i.phase == PH_VALUE) begin
         o.st.value_begun = 1'b1;
         if (s_i.value_begun || (b != CHAR_SPACE)) begin
            if (s_i.host_match) begin
               if (!s_i.host_colon && (b == CHAR_COLON)) begin
                  o.st.host_colon = 1'b1;
                  o.st.port_count = '0;
                  o.st.port_ovf   = 1'b0;
               end else if (!s_i.host_colon) begin
                  if (s_i.host_count < HCNT_W'(MAX_HOST)) begin
                     o.host_we       = 1'b1;
                     o.host_addr     = s_i.host_count[HIDX_W-1:0];
                     o.st.host_count = s_i.host_count + HCNT_W'(1);
                  end else begin
                     o.st.host_ovf = 1'b1;
                  end
               end else begin
                  if (s_i.port_count < PCNT_W'(MAX_PORT)) begin
                     o.port_we       = 1'b1;
                     o.port_addr     = s_i.port_count[PIDX_W-1:0];
                     o.st.port_count = s_i.port_count + PCNT_W'(1);
                  end else begin
                     o.st.port_ovf = 1'b1;
                  end
               end
            end
            if (s_i.len_match) begin
               if (!s_i.value_nonempty) begin
                  ok = digit;
               end else if (!digit) begin
                  ok = 1'b0;
               end
               o.st.value_nonempty = 1'b1;
               if (ok) begin
                  if (prod[ACC_X_W-1 -: 4] != 4'd0) begin
                     ok = 1'b0;
                  end else begin
                     o.st.len_acc = prod[LENGTH_BITS-1:0];
                  end
               end
               o.st.len_ok = ok;
            end
         end
      end
      return o;
   endfunction

   parse_state_type    st_ff;
   parse_state_type    st_in;
   logic [BYTE_W-1:0]  port_ff [MAX_PORT];
   logic [BYTE_W-1:0]  port_in [MAX_PORT];

   parse_state_type    s;
   content_out_type    c1;
   content_out_type    c2;
   logic               p1_we;
   logic [PIDX_W-1:0]  p1_addr;
   logic               p2_we;
   logic [PIDX_W-1:0]  p2_addr;
   logic               def_port;
   logic               host_we;
   logic [HIDX_W-1:0]  host_addr;
   logic               host_rd;
   logic [HCMP_W-1:0]  h_idx;
   logic [PCMP_W-1:0]  p_idx;

   assign h_idx   = HCMP_W'(item.read_index);
   assign p_idx   = PCMP_W'(item.read_index);
   assign host_rd = step && (item.mode == MODE_HOST);

   always_comb begin
      st_in    = st_ff;
      s        = st_ff;
      c1       = '0;
      c2       = '0;
      p1_we    = 1'b0;
      p1_addr  = '0;
      p2_we    = 1'b0;
      p2_addr  = '0;
      def_port = 1'b0;
      host_we  = 1'b0;
      host_addr = '0;
      result   = '0;
      if (step) begin
         case (item.mode)
            MODE_HOST: begin
               result.has_result = 1'b1;
               result.host_read  = 1'b1;
               result.host_hit   = (h_idx < HCMP_W'(st_ff.host_count))
                                   && (h_idx < HCMP_W'(MAX_HOST));
               result.rsp.kind   = KIND_READ;
            end
            MODE_PORT: begin
               result.has_result = 1'b1;
               result.rsp.kind   = KIND_READ;
               if ((p_idx < PCMP_W'(st_ff.port_count)) && (p_idx < PCMP_W'(MAX_PORT))) begin
                  result.rsp.read_byte = port_ff[p_idx[PIDX_W-1:0]];
               end
            end
            MODE_MSG: begin
               if (item.first_byte) begin
                  s = cleared_state();
               end
               if (s.phase != PH_DONE) begin
                  if (s.cr_pending && (item.data_byte == CHAR_LF)) begin
                     s.cr_pending = 1'b0;
                     s = end_line(s);
                  end else begin
                     if (s.cr_pending) begin
                        s.cr_pending = 1'b0;
                        c1      = apply_content(s, CHAR_CR);
                        s       = c1.st;
                        p1_we   = c1.port_we;
                        p1_addr = c1.port_addr;
                     end
                     // A carriage return is written to the host store at once; it only
                     // counts once the following byte shows it is content.
                     c2        = apply_content(s, item.data_byte);
                     host_we   = c2.host_we;
                     host_addr = c2.host_addr;
                     if ((item.data_byte != CHAR_CR) || item.last_byte) begin
                        s       = c2.st;
                        p2_we   = c2.port_we;
                        p2_addr = c2.port_addr;
                     end else begin
                        s.cr_pending = 1'b1;
                     end
                  end
                  if (item.last_byte) begin
                     s = end_line(s);
                  end
               end
               if (item.last_byte) begin
                  s.phase      = PH_DONE;
                  s.cr_pending = 1'b0;
                  if (s.port_count == '0) begin
                     def_port     = 1'b1;
                     s.port_count = PCNT_W'(2);
                     s.port_ovf   = 1'b0;
                  end
                  result.has_result              = 1'b1;
                  result.rsp.kind                = KIND_SUMMARY;
                  result.rsp.host_length         = HLEN_W'(s.host_count);
                  result.rsp.port_length         = PLEN_W'(s.port_count);
                  result.rsp.host_missing        = (s.host_count == '0);
                  result.rsp.port_defaulted      = def_port;
                  result.rsp.host_truncated      = s.host_ovf;
                  result.rsp.port_truncated      = s.port_ovf;
                  result.rsp.length_found        = s.len_done;
                  result.rsp.content_length      = s.len_done ? CLEN_W'(s.len_value) : '0;
               end
               st_in = s;
            end
            default: begin
               st_in = st_ff;
            end
         endcase
      end
   end

   always_comb begin
      port_in = port_ff;
      if (p1_we) begin
         port_in[p1_addr] = CHAR_CR;
      end
      if (p2_we) begin
         port_in[p2_addr] = item.data_byte;
      end
      if (def_port) begin
         port_in[0] = CHAR_EIGHT;
         port_in[1] = CHAR_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= cleared_state();
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      port_ff <= port_in;
   end

   hhlp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_HOST)
   ) u_host_ram (
      .clock   (clock),
      .wr_en   (host_we),
      .wr_addr (host_addr),
      .wr_data (item.data_byte),
      .rd_en   (host_rd),
      .rd_addr (h_idx[HIDX_W-1:0]),
      .rd_data (host_q)
   );

   a_pending_not_done: assert property (@(posedge clock) disable iff (reset)
      !(st_ff.cr_pending && (st_ff.phase == PH_DONE)))
      else $error("A carriage return is pending after the header section ended.");

   a_host_count_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff.host_count <= HCNT_W'(MAX_HOST))
      else $error("The host byte count exceeds the host store.");

   a_host_ovf_full: assert property (@(posedge clock) disable iff (reset)
      st_ff.host_ovf |-> (st_ff.host_count == HCNT_W'(MAX_HOST)))
      else $error("Host truncation is flagged while the host store is not full.");

   a_port_ovf_full: assert property (@(posedge clock) disable iff (reset)
      st_ff.port_ovf |-> (st_ff.port_count == PCNT_W'(MAX_PORT)))
      else $error("Port truncation is flagged while the port store is not full.");
endmodule

// ===== sv/http_header_host_length_parser_unit.sv =====
// A request accepted into the input register gives its response from the response register.
// Throughput: one request per cycle; the input register and the response register
// each advance whenever the response register is empty or being taken.
// Reset (synchronous) clears the parse state and both valid flags; the host store
// keeps its contents and needs no clearing pass.
module http_header_host_length_parser_unit import hhlp_pkg::*; (
   input logic       clock,
   input logic       reset,
   hhlp_req_if.sink   req_bus,
   hhlp_rsp_if.source rsp_bus
);
   req_item_type    in_ff;
   logic            in_valid_ff;
   logic            in_valid_in;
   rsp_item_type    out_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   logic            host_read_ff;
   logic            host_hit_ff;
   logic            out_free;
   logic            step;
   logic            accept;
   core_result_type result;
   logic [BYTE_W-1:0] host_q;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;
   assign accept        = req_bus.valid && req_bus.ready;

   assign in_valid_in  = accept ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = step ? result.has_result : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff.mode       <= req_bus.mode;
         in_ff.data_byte  <= req_bus.data_byte;
         in_ff.first_byte <= req_bus.first_byte;
         in_ff.last_byte  <= req_bus.last_byte;
         in_ff.read_index <= req_bus.read_index;
      end
      if (step) begin
         out_ff       <= result.rsp;
         host_read_ff <= result.host_read;
         host_hit_ff  <= result.host_hit;
      end
   end

   hhlp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_ff),
      .result (result),
      .host_q (host_q)
   );

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.kind           = out_ff.kind;
   assign rsp_bus.read_byte      = host_read_ff ? (host_hit_ff ? host_q : '0)
                                                : out_ff.read_byte;
   assign rsp_bus.host_length    = out_ff.host_length;
   assign rsp_bus.port_length    = out_ff.port_length;
   assign rsp_bus.host_missing   = out_ff.host_missing;
   assign rsp_bus.port_defaulted = out_ff.port_defaulted;
   assign rsp_bus.host_truncated = out_ff.host_truncated;
   assign rsp_bus.port_truncated = out_ff.port_truncated;
   assign rsp_bus.length_found   = out_ff.length_found;
   assign rsp_bus.content_length = out_ff.content_length;
endmodule
